[rtl/core/scm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scm_pkg
// Shared constants and types for the stick cutting minimum cost block.
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_POS_BITS   = 16;

    localparam int COST_W = 24;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MANY = 2'd2;

    // Status flags that the solver reports to the control logic.
    typedef struct packed {
        logic busy;
        logic done;
    } solve_stat_t;

endpackage : scm_pkg
`default_nettype wire

[rtl/core/scm_point_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scm_point_mem
// Point store: one write port, one read port with a registered read.
// ----------------------------------------------------------------------------
module scm_point_mem #(
    parameter int MAX_POINTS = scm_pkg::DEF_MAX_POINTS,
    parameter int POS_BITS   = scm_pkg::DEF_POS_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(MAX_POINTS)-1:0] wr_addr,
    input  wire logic [POS_BITS-1:0]           wr_data,
    input  wire logic [$clog2(MAX_POINTS)-1:0] rd_addr,
    output logic      [POS_BITS-1:0]           rd_data
);

    logic [POS_BITS-1:0] mem [0:MAX_POINTS-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule : scm_point_mem
`default_nettype wire

[rtl/core/scm_cost_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scm_cost_mem
// Interval cost table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module scm_cost_mem #(
    parameter int ADDR_W = 12
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic [scm_pkg::COST_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]          rd_addr_a,
    input  wire logic [ADDR_W-1:0]          rd_addr_b,
    output logic      [scm_pkg::COST_W-1:0] rd_data_a,
    output logic      [scm_pkg::COST_W-1:0] rd_data_b
);

    logic [scm_pkg::COST_W-1:0] mem [0:(2**ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule : scm_cost_mem
`default_nettype wire

[rtl/core/scm_solver.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scm_solver
// Interval sequencer: walks the intervals by growing width, reads the split
// costs from the cost table, keeps the cheapest and writes it back.
// ----------------------------------------------------------------------------
module scm_solver #(
    parameter int MAX_POINTS = scm_pkg::DEF_MAX_POINTS,
    parameter int POS_BITS   = scm_pkg::DEF_POS_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [$clog2(MAX_POINTS)-1:0] pieces,
    output logic      [$clog2(MAX_POINTS)-1:0] pt_rd_addr,
    input  wire logic [POS_BITS-1:0]           pt_rd_data,
    output scm_pkg::solve_stat_t               stat,
    output logic      [scm_pkg::COST_W-1:0]    cost
);

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int COST_W = scm_pkg::COST_W;
    localparam int DBL_W  = POS_BITS + 1;
    localparam int WIDE_W = (DBL_W > COST_W) ? DBL_W : COST_W;
    localparam int SUM_W  = COST_W + 2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LO    = 3'd1;
    localparam logic [2:0] ST_HI    = 3'd2;
    localparam logic [2:0] ST_SEG   = 3'd3;
    localparam logic [2:0] ST_LOOP  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_WRITE = 3'd6;

    logic [2:0]        state_reg;
    logic [IDX_W-1:0]  pieces_reg;
    logic [IDX_W-1:0]  d_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  k_reg;
    logic              done_reg;
    logic [POS_BITS-1:0] lo_reg;
    logic [COST_W-1:0] seg_reg;
    logic [COST_W-1:0] best_reg;
    logic              v1_reg;
    logic              za_reg;
    logic              zb_reg;
    logic              v2_reg;
    logic [COST_W-1:0] sum_reg;

    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [COST_W-1:0] rd_data_a;
    logic [COST_W-1:0] rd_data_b;
    logic              wr_en;
    logic [IDX_W-1:0]  k_plus;
    logic [IDX_W:0]    j_plus;
    logic [IDX_W:0]    d_plus;

    logic [POS_BITS-1:0] len;
    logic [DBL_W-1:0]    dbl;
    logic [WIDE_W-1:0]   dbl_wide;
    logic [COST_W-1:0]   seg_next;
    logic [COST_W-1:0]   op_a;
    logic [COST_W-1:0]   op_b;
    logic [SUM_W-1:0]    sum_full;
    logic [COST_W-1:0]   sum_next;

    assign k_plus = k_reg + 1'b1;
    assign j_plus = {1'b0, j_reg} + 1'b1;
    assign d_plus = {1'b0, d_reg} + 1'b1;

    assign pt_rd_addr = (state_reg == ST_HI) ? j_plus[IDX_W-1:0] : i_reg;
    assign rd_addr_a  = {i_reg, k_reg};
    assign rd_addr_b  = {k_plus, j_reg};
    assign wr_en      = (state_reg == ST_WRITE);

    // Segment cost: twice the length, length clipped at zero, saturated.
    assign len      = (pt_rd_data > lo_reg) ? (pt_rd_data - lo_reg) : '0;
    assign dbl      = {len, 1'b0};
    assign dbl_wide = WIDE_W'(dbl);
    assign seg_next = (dbl_wide > WIDE_W'(scm_pkg::COST_MAX)) ? scm_pkg::COST_MAX
                                                               : dbl_wide[COST_W-1:0];

    // Diagonal entries are never stored; they read as zero.
    assign op_a     = za_reg ? '0 : rd_data_a;
    assign op_b     = zb_reg ? '0 : rd_data_b;
    assign sum_full = SUM_W'(op_a) + SUM_W'(op_b) + SUM_W'(seg_reg);
    assign sum_next = (sum_full > SUM_W'(scm_pkg::COST_MAX)) ? scm_pkg::COST_MAX
                                                              : sum_full[COST_W-1:0];

    scm_cost_mem #(
        .ADDR_W (ADDR_W)
    ) u_cost_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   ({i_reg, j_reg}),
        .wr_data   (best_reg),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            v1_reg   <= (state_reg == ST_LOOP);
            v2_reg   <= v1_reg;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (pieces == IDX_W'(1))
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_LO;
                        end
                    end
                end
                ST_LO:    state_reg <= ST_HI;
                ST_HI:    state_reg <= ST_SEG;
                ST_SEG:   state_reg <= ST_LOOP;
                ST_LOOP:
                begin
                    if (k_plus == j_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    if (j_plus < {1'b0, pieces_reg})
                    begin
                        state_reg <= ST_LO;
                    end
                    else if (d_plus < {1'b0, pieces_reg})
                    begin
                        state_reg <= ST_LO;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        za_reg  <= (k_reg == i_reg);
        zb_reg  <= (k_plus == j_reg);
        sum_reg <= sum_next;
        if (v2_reg && (sum_reg < best_reg))
        begin
            best_reg <= sum_reg;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    pieces_reg <= pieces;
                    d_reg      <= IDX_W'(1);
                    i_reg      <= '0;
                    j_reg      <= IDX_W'(1);
                    best_reg   <= '0;
                end
            end
            ST_HI:
            begin
                lo_reg <= pt_rd_data;
            end
            ST_SEG:
            begin
                seg_reg  <= seg_next;
                k_reg    <= i_reg;
                best_reg <= scm_pkg::COST_MAX;
            end
            ST_LOOP:
            begin
                k_reg <= k_plus;
            end
            ST_WRITE:
            begin
                if (j_plus < {1'b0, pieces_reg})
                begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= j_plus[IDX_W-1:0];
                end
                else if (d_plus < {1'b0, pieces_reg})
                begin
                    d_reg <= d_plus[IDX_W-1:0];
                    i_reg <= '0;
                    j_reg <= d_plus[IDX_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = done_reg;
    assign cost      = best_reg;

endmodule : scm_solver
`default_nettype wire

[rtl/core/stick_cutting_min_cost.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stick_cutting_min_cost
// Collects the points of a stick and finds the minimum total cost of cutting
// it at all inner points, where each cut costs twice the segment length.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                   Payload                 Width
//  -------  --------------------------  ----------------------  ---------------
//  item     item_valid / item_ready     position, last_point    POS_BITS, 1
//  result   result_valid / result_ready min_cost, status        24, 2
//
// Each point is stored while the point store has room. The point that
// closes a sequence starts the interval solver when the sequence is valid.
// With P = points - 1 pieces, the solver works through each of the P - d
// intervals of width d (two point reads, the split loop over the cost
// table read ports, the pipeline drain and the write back). An error
// status waits as a pending result until the output register is free.
// Reset needs no clearing pass: the cost table is written before it is read,
// and diagonal entries are supplied as zero.
// After a closing point, item_ready stays low until its result moves into the
// output register; a result waiting there does not block the loading of the
// next points, only the hand-over of the next closing point's result.
// ----------------------------------------------------------------------------
module stick_cutting_min_cost #(
    parameter int MAX_POINTS = scm_pkg::DEF_MAX_POINTS,
    parameter int POS_BITS   = scm_pkg::DEF_POS_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire logic [POS_BITS-1:0]          position,
    input  wire logic                         last_point,
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output logic      [scm_pkg::COST_W-1:0]   min_cost,
    output logic      [scm_pkg::STATUS_W-1:0] status
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 2);

    logic [CNT_W-1:0]            point_count_reg;
    logic                        overflow_seen_reg;
    logic                        busy_reg;
    logic                        pend_done_reg;
    logic [scm_pkg::STATUS_W-1:0] pend_status_reg;
    logic                        result_valid_reg;
    logic [scm_pkg::COST_W-1:0]  min_cost_reg;
    logic [scm_pkg::STATUS_W-1:0] status_reg;

    logic                        item_acc;
    logic                        has_room;
    logic [CNT_W-1:0]            count_next;
    logic                        overflow_next;
    logic [scm_pkg::STATUS_W-1:0] seq_status;
    logic                        solve_start;
    logic                        deliver;

    logic [IDX_W-1:0]            pt_rd_addr;
    logic [POS_BITS-1:0]         pt_rd_data;
    scm_pkg::solve_stat_t        solve_stat;
    logic [scm_pkg::COST_W-1:0]  solve_cost;

    assign item_ready = !busy_reg;
    assign item_acc   = item_valid && item_ready;
    assign has_room   = (point_count_reg < CNT_W'(MAX_POINTS));

    // Points beyond the store are dropped and flag the sequence as too long.
    assign count_next    = has_room ? (point_count_reg + 1'b1) : CNT_W'(MAX_POINTS + 1);
    assign overflow_next = overflow_seen_reg || !has_room;

    always_comb
    begin
        if (overflow_next)
        begin
            seq_status = scm_pkg::STATUS_MANY;
        end
        else if (count_next < CNT_W'(2))
        begin
            seq_status = scm_pkg::STATUS_FEW;
        end
        else
        begin
            seq_status = scm_pkg::STATUS_OK;
        end
    end

    assign solve_start = item_acc && last_point && (seq_status == scm_pkg::STATUS_OK);

    // A finished result moves to the output register once that is free.
    assign deliver = busy_reg && pend_done_reg && (!result_valid_reg || result_ready);

    scm_point_mem #(
        .MAX_POINTS (MAX_POINTS),
        .POS_BITS   (POS_BITS)
    ) u_point_mem (
        .clk     (clk),
        .wr_en   (item_acc && has_room),
        .wr_addr (point_count_reg[IDX_W-1:0]),
        .wr_data (position),
        .rd_addr (pt_rd_addr),
        .rd_data (pt_rd_data)
    );

    scm_solver #(
        .MAX_POINTS (MAX_POINTS),
        .POS_BITS   (POS_BITS)
    ) u_solver (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (solve_start),
        .pieces     (IDX_W'(count_next - 1'b1)),
        .pt_rd_addr (pt_rd_addr),
        .pt_rd_data (pt_rd_data),
        .stat       (solve_stat),
        .cost       (solve_cost)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg   <= '0;
            overflow_seen_reg <= 1'b0;
            busy_reg          <= 1'b0;
            pend_done_reg     <= 1'b0;
            pend_status_reg   <= scm_pkg::STATUS_OK;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_acc)
            begin
                if (last_point)
                begin
                    point_count_reg   <= '0;
                    overflow_seen_reg <= 1'b0;
                    busy_reg          <= 1'b1;
                    pend_status_reg   <= seq_status;
                    pend_done_reg     <= (seq_status != scm_pkg::STATUS_OK);
                end
                else
                begin
                    point_count_reg   <= count_next;
                    overflow_seen_reg <= overflow_next;
                end
            end

            if (solve_stat.done)
            begin
                pend_done_reg <= 1'b1;
            end

            if (deliver)
            begin
                busy_reg         <= 1'b0;
                pend_done_reg    <= 1'b0;
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (deliver)
        begin
            status_reg   <= pend_status_reg;
            min_cost_reg <= (pend_status_reg == scm_pkg::STATUS_OK) ? solve_cost : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign min_cost     = min_cost_reg;
    assign status       = status_reg;

    // The solver only finishes for a valid sequence that is still pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        solve_stat.done |-> busy_reg && !pend_done_reg &&
                            (pend_status_reg == scm_pkg::STATUS_OK))
        else $error("solver finished without a pending valid sequence");

    // An error transaction never carries a cost.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != scm_pkg::STATUS_OK) |-> (min_cost == '0))
        else $error("error result with nonzero cost");

    // The overflow flag only stands with the count pinned past the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        overflow_seen_reg |-> (point_count_reg == CNT_W'(MAX_POINTS + 1)))
        else $error("overflow flag without saturated count");

    // The solver runs only while the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        solve_stat.busy |-> busy_reg)
        else $error("solver active while the block is idle");

endmodule : stick_cutting_min_cost
`default_nettype wire
